### rtl/rmcrc_pkg.sv
`default_nettype none

package rmcrc_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int LEN_W          = 24;
    localparam int CRC_W          = 32;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int HEAD_BYTES     = 8;

    localparam logic [CRC_W-1:0] CRC_POLY  = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]       JUMP_KEEP = 8'hFC;
    localparam logic [1:0]       WORD_LAST = 2'd3;

    typedef enum logic [1:0] {
        RELOC_NONE   = 2'd0,
        RELOC_JUMP26 = 2'd1,
        RELOC_HALF16 = 2'd2
    } t_reloc;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SECTION_LENGTH = 2'd0,
        CFG_EXP_HEAD_CRC   = 2'd1,
        CFG_EXP_FULL_CRC   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] reloc_start;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic             matched;
        logic             length_ok;
        logic             head_crc_ok;
        logic [CRC_W-1:0] full_crc;
    } t_result;

    typedef struct packed {
        logic [LEN_W-1:0] section_length;
        logic [CRC_W-1:0] expected_head_crc;
        logic [CRC_W-1:0] expected_full_crc;
    } t_cfg;

    // reflected crc-32c, one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-8){1'b0}}, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/rmcrc_if.sv
`default_nettype none

interface rmcrc_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/rmcrc_core.sv
`default_nettype none

module rmcrc_core #(
    parameter int COUNT_BITS = rmcrc_pkg::COUNT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire rmcrc_pkg::t_item   i_item,
    input  wire rmcrc_pkg::t_cfg    i_cfg,
    output rmcrc_pkg::t_result      o_result
);

    localparam int CMP_W = (COUNT_BITS > rmcrc_pkg::LEN_W) ? COUNT_BITS : rmcrc_pkg::LEN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_HEAD = COUNT_BITS'(rmcrc_pkg::HEAD_BYTES);

    logic [rmcrc_pkg::CRC_W-1:0] r_crc, n_crc;
    logic [rmcrc_pkg::CRC_W-1:0] r_head, n_head;
    logic [COUNT_BITS-1:0]       r_count, n_count;
    logic [1:0]                  r_left, n_left;
    logic                        r_jump, n_jump;
    logic [7:0]                  masked;
    logic [rmcrc_pkg::CRC_W-1:0] full;
    logic [rmcrc_pkg::CRC_W-1:0] head;
    logic                        len_ok;
    logic                        head_ok;

    always_comb begin
        masked = i_item.data_byte;
        n_left = r_left;
        n_jump = r_jump;
        // bytes still covered by an earlier word
        if (r_left != 2'd0) begin
            if (r_jump || r_left <= 2'd2) begin
                masked = 8'h00;
            end
            n_left = r_left - 2'd1;
        end
        unique case (i_item.reloc_start)
            rmcrc_pkg::RELOC_JUMP26: begin
                masked = masked & rmcrc_pkg::JUMP_KEEP;
                n_jump = 1'b1;
                n_left = rmcrc_pkg::WORD_LAST;
            end
            rmcrc_pkg::RELOC_HALF16: begin
                n_jump = 1'b0;
                n_left = rmcrc_pkg::WORD_LAST;
            end
            default: begin
            end
        endcase

        n_crc   = rmcrc_pkg::crc_byte(r_crc, masked);
        n_count = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;
        n_head  = (n_count == COUNT_HEAD) ? ~n_crc : r_head;

        full    = ~n_crc;
        head    = (n_count < COUNT_HEAD) ? full : n_head;
        len_ok  = CMP_W'(n_count) == CMP_W'(i_cfg.section_length);
        head_ok = head == i_cfg.expected_head_crc;

        o_result.length_ok   = len_ok;
        o_result.head_crc_ok = head_ok;
        o_result.full_crc    = full;
        o_result.matched     = len_ok && head_ok && (full == i_cfg.expected_full_crc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= rmcrc_pkg::CRC_INIT;
            r_head  <= '0;
            r_count <= '0;
            r_left  <= 2'd0;
            r_jump  <= 1'b0;
        end else if (i_adv) begin
            if (i_item.last_byte) begin
                // a word cut by the end is dropped with the rest of the stream
                r_crc   <= rmcrc_pkg::CRC_INIT;
                r_head  <= '0;
                r_count <= '0;
                r_left  <= 2'd0;
                r_jump  <= 1'b0;
            end else begin
                r_crc   <= n_crc;
                r_head  <= n_head;
                r_count <= n_count;
                r_left  <= n_left;
                r_jump  <= n_jump;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_item.last_byte |=> r_count == '0 && r_crc == rmcrc_pkg::CRC_INIT
                                      && r_left == 2'd0)
        else $error("stream state not cleared after last item");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_item.last_byte && r_count == COUNT_MAX |=> r_count == COUNT_MAX)
        else $error("byte count wrapped");

    a_head_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_item.last_byte && n_count == COUNT_HEAD |=> r_head == ~r_crc)
        else $error("head crc not captured at eighth byte");

endmodule

`default_nettype wire

### rtl/reloc_masked_crc32c_match.sv
// Relocation-masked CRC-32C matcher. Takes one candidate byte per item on i_in and
// keeps a reflected CRC-32C (init all ones, final invert) over the bytes after
// masking relocated big-endian words: a jump26 start keeps the top 6 bits of the
// word, a half16 start zeroes its low two bytes. Only an item with last_byte set
// gives a result on o_res (matched, length_ok, head_crc_ok, full_crc) and then
// clears the stream state for the next candidate. An item is taken every cycle
// unless a last item is held; each item waits in the input register while the
// CRC byte update and the compares run. The result register takes the outcome
// as a last item advances, so o_res.valid rises in the next cycle. A last item
// is only held in the input register while an earlier result waits unaccepted
// on o_res. The byte counter saturates at 2^COUNT_BITS-1. Configuration (index
// 0 section_length, reset 1; 1 expected_head_crc and 2 expected_full_crc, reset
// 0) must be written through i_cfg_we only while idle; the block does not check.
`default_nettype none

module reloc_masked_crc32c_match #(
    parameter int COUNT_BITS = rmcrc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rmcrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rmcrc_pkg::CFG_W-1:0]     i_cfg_data,
    rmcrc_if.sink                                i_in,
    rmcrc_if.source                              o_res
);

    rmcrc_pkg::t_cfg    r_cfg;
    rmcrc_pkg::t_item   r_in;
    logic               r_in_valid;
    rmcrc_pkg::t_result r_out;
    logic               r_out_valid;
    rmcrc_pkg::t_result step_result;
    logic               out_free;
    logic               adv;

    assign out_free    = !r_out_valid || o_res.ready;
    // a last item waits in the input register while the result slot is full
    assign adv         = r_in_valid && (!r_in.last_byte || out_free);
    assign i_in.ready  = !r_in_valid || adv;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.section_length    <= rmcrc_pkg::LEN_W'(1);
            r_cfg.expected_head_crc <= '0;
            r_cfg.expected_full_crc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rmcrc_pkg::CFG_SECTION_LENGTH:
                    r_cfg.section_length <= i_cfg_data[rmcrc_pkg::LEN_W-1:0];
                rmcrc_pkg::CFG_EXP_HEAD_CRC:
                    r_cfg.expected_head_crc <= i_cfg_data[rmcrc_pkg::CRC_W-1:0];
                rmcrc_pkg::CFG_EXP_FULL_CRC:
                    r_cfg.expected_full_crc <= i_cfg_data[rmcrc_pkg::CRC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (adv && r_in.last_byte) begin
            r_out <= step_result;
        end
    end

    rmcrc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in.last_byte && r_out_valid && !o_res.ready |-> !i_in.ready)
        else $error("input taken while a last item is blocked");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.last_byte))
        else $error("result without a last item");

    a_no_result_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> r_out_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire
